// ----- design/srec_pkg.sv -----
`default_nettype none

package srec_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_S     = 2'd1;
    localparam logic [1:0] ERR_BAD_TYPE = 2'd2;

    // One result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  record_type;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        logic [7:0]  payload_length;
        logic        checksum_ok;
        logic [1:0]  error_code;
    } t_result;

endpackage

`default_nettype wire

// ----- design/srec_in_reg.sv -----
`default_nettype none

module srec_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_char_in,
    output logic            o_stall,
    input  wire logic       i_advance,
    output logic            o_held,
    output logic [7:0]      o_char
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       w_accept;

    // The register frees up in the same cycle its beat moves on.
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= i_char_in;
        end
    end

    assign o_held = r_valid;
    assign o_char = r_char;

endmodule

`default_nettype wire

// ----- design/srec_core.sv -----
`default_nettype none

module srec_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    input  wire logic [7:0]  i_char,
    output logic             o_res_valid,
    output srec_pkg::t_result o_res
);

    import srec_pkg::*;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [9:0] POS_MAX    = 10'd1023;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    // Hex digit decode; anything else reads as zero.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = c - CHAR_ZERO;
            end else if (c >= CHAR_UA && c <= CHAR_UF) begin
                d = c - CHAR_UA + 8'd10;
            end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
                d = c - CHAR_LA + 8'd10;
            end
            nibble_of = d[3:0];
        end
    endfunction

    logic [9:0]  r_pos,  n_pos;
    logic [3:0]  r_type, n_type;
    logic [2:0]  r_abc,  n_abc;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_dlen, n_dlen;
    logic [7:0]  r_sum,  n_sum;
    logic [3:0]  r_hi,   n_hi;
    logic [7:0]  r_pidx, n_pidx;
    logic        r_skip, n_skip;

    logic [7:0]  w_need;
    logic [7:0]  w_plen;
    logic [7:0]  w_byte;
    logic [8:0]  w_idx;
    logic        w_line_end;

    // Payload length from the count and the address width.
    assign w_need = {5'd0, r_abc} + 8'd1;
    assign w_plen = (r_dlen <= w_need) ? 8'd0 : (r_dlen - w_need);
    assign w_byte = {r_hi, nibble_of(i_char)};
    assign w_idx  = r_pos[9:1] - 9'd1;
    assign w_line_end = (i_char == CHAR_CR) || (i_char == CHAR_LF);

    // Next state and the result caused by the current character.
    always_comb begin
        n_pos  = r_pos;
        n_type = r_type;
        n_abc  = r_abc;
        n_addr = r_addr;
        n_dlen = r_dlen;
        n_sum  = r_sum;
        n_hi   = r_hi;
        n_pidx = r_pidx;
        n_skip = r_skip;
        o_res_valid = 1'b0;
        o_res = '0;

        if (w_line_end) begin
            if (!r_skip && r_pos != 10'd0) begin
                o_res_valid = 1'b1;
                if (r_pos == 10'd1) begin
                    o_res.kind       = KIND_REJECT;
                    o_res.error_code = ERR_BAD_TYPE;
                end else begin
                    o_res.kind           = KIND_DONE;
                    o_res.record_type    = r_type;
                    o_res.address        = r_addr;
                    o_res.payload_length = w_plen;
                    o_res.checksum_ok    = (r_sum == SUM_GOOD);
                end
            end
            n_pos  = 10'd0;
            n_type = 4'd0;
            n_abc  = 3'd2;
            n_addr = 32'd0;
            n_dlen = 8'd0;
            n_sum  = 8'd0;
            n_hi   = 4'd0;
            n_pidx = 8'd0;
            n_skip = 1'b0;
        end else if (r_skip) begin
            n_skip = 1'b1;
        end else if (r_pos == 10'd0) begin
            if (i_char != CHAR_S) begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_REJECT;
                o_res.error_code = ERR_NO_S;
                n_skip           = 1'b1;
            end else begin
                n_pos = 10'd1;
            end
        end else if (r_pos == 10'd1) begin
            n_type = i_char[3:0];
            n_pos  = 10'd2;
            case (i_char)
                CHAR_ZERO, CHAR_ZERO + 8'd1, CHAR_ZERO + 8'd5, CHAR_NINE: begin
                    n_abc = 3'd2;
                end
                CHAR_ZERO + 8'd2, CHAR_ZERO + 8'd8: begin
                    n_abc = 3'd3;
                end
                CHAR_ZERO + 8'd3, CHAR_ZERO + 8'd7: begin
                    n_abc = 3'd4;
                end
                default: begin
                    n_type           = r_type;
                    n_pos            = r_pos;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_REJECT;
                    o_res.error_code = ERR_BAD_TYPE;
                    n_skip           = 1'b1;
                end
            endcase
        end else begin
            if (!r_pos[0]) begin
                n_hi = nibble_of(i_char);
            end else if (w_idx == 9'd0) begin
                n_dlen = w_byte;
                n_sum  = r_sum + w_byte;
            end else if (w_idx <= {1'b0, r_dlen}) begin
                n_sum = r_sum + w_byte;
                if (w_idx <= {6'd0, r_abc}) begin
                    n_addr = {r_addr[23:0], w_byte};
                end else if (r_pidx < w_plen) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_DATA;
                    o_res.record_type    = r_type;
                    o_res.address        = r_addr;
                    o_res.data_byte      = w_byte;
                    o_res.byte_offset    = r_pidx;
                    o_res.payload_length = w_plen;
                    n_pidx               = r_pidx + 8'd1;
                end
            end
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + 10'd1;
            end
        end
    end

    // Line state moves only when a character beat advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 10'd0;
            r_type <= 4'd0;
            r_abc  <= 3'd2;
            r_addr <= 32'd0;
            r_dlen <= 8'd0;
            r_sum  <= 8'd0;
            r_hi   <= 4'd0;
            r_pidx <= 8'd0;
            r_skip <= 1'b0;
        end else if (i_advance) begin
            r_pos  <= n_pos;
            r_type <= n_type;
            r_abc  <= n_abc;
            r_addr <= n_addr;
            r_dlen <= n_dlen;
            r_sum  <= n_sum;
            r_hi   <= n_hi;
            r_pidx <= n_pidx;
            r_skip <= n_skip;
        end
    end

`ifndef NO_ASSERTIONS
    // A skipped line stays silent, its closing line end included.
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> !o_res_valid)
        else $error("result produced while skipping a line");

    // Each payload beat bumps the offset by one.
    a_pidx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_res.kind == KIND_DATA)
        |=> (r_pidx == $past(r_pidx) + 8'd1))
        else $error("payload offset did not advance");

    // A rejection always starts a skipped line unless it closes the line.
    a_reject_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_res.kind == KIND_REJECT && !w_line_end)
        |=> r_skip)
        else $error("rejection did not start skipping");

    // Payload beats never run past the computed payload length.
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_DATA)
        |-> (o_res.byte_offset < o_res.payload_length))
        else $error("payload offset beyond payload length");
`endif

endmodule

`default_nettype wire

// ----- design/srec_out_reg.sv -----
`default_nettype none

module srec_out_reg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_stall,
    input  wire logic        i_res_valid,
    input  wire srec_pkg::t_result i_res,
    input  wire logic        i_advance,
    output logic             o_ready,
    output logic             o_valid,
    output srec_pkg::t_result o_res
);

    import srec_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register takes a new beat when empty or when its beat is taken.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_advance && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ----- design/srecord_line_parser.sv -----
// Motorola S-record line parser. One ASCII character enters per cycle on the
// valid/stall input channel; each character yields at most one result beat on
// the output channel, passing through the input register, parser and result
// register. A result is a payload byte with its offset, a record-complete
// beat at CR or LF carrying the checksum verdict, or a rejection for a line
// that lacks the leading S or has an undefined type; a rejected line is then
// ignored up to its line end. Sustained rate is one character per cycle; the
// input side stalls only while a result waits in the output register and the
// next character is already held in the input register.
`default_nettype none

module srecord_line_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic [7:0] i_char_in,
    output logic       o_stall,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [1:0] o_kind,
    output logic [3:0] o_record_type,
    output logic [31:0] o_address,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_offset,
    output logic [7:0] o_payload_length,
    output logic       o_checksum_ok,
    output logic [1:0] o_error_code
);

    import srec_pkg::*;

    logic       w_held;
    logic [7:0] w_char;
    logic       w_out_ready;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    // A held character moves through the parser when the result register is free.
    assign w_advance = w_held && w_out_ready;

    srec_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .o_stall   (o_stall),
        .i_advance (w_advance),
        .o_held    (w_held),
        .o_char    (w_char)
    );

    srec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_char      (w_char),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    srec_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stall     (i_stall),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_advance   (w_advance),
        .o_ready     (w_out_ready),
        .o_valid     (o_valid),
        .o_res       (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_record_type    = w_out.record_type;
    assign o_address        = w_out.address;
    assign o_data_byte      = w_out.data_byte;
    assign o_byte_offset    = w_out.byte_offset;
    assign o_payload_length = w_out.payload_length;
    assign o_checksum_ok    = w_out.checksum_ok;
    assign o_error_code     = w_out.error_code;

endmodule

`default_nettype wire

// ----- tb/srecord_line_parser_test.sv -----
`timescale 1ns / 1ps

module srecord_line_parser_test;
    import srec_pkg::*;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_S  = "S";
    localparam logic [9:0] POS_LIMIT = 10'd1023;
    localparam int LIVE_CHAR_TARGET = 1400;
    localparam int SHOWN_MISMATCHES = 10;

    // How a directed row is checked.
    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_GIVEN} t_check_how;

    typedef struct packed {
        logic [7:0] ch;
        t_check_how how;
        t_result    given;
    } t_dir_row;

    localparam t_result NO_BEAT = '0;

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_in = 8'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_record_type;
    logic [31:0] o_address;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_byte_offset;
    logic [7:0]  o_payload_length;
    logic        o_checksum_ok;
    logic [1:0]  o_error_code;

    srecord_line_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_char_in        (i_char_in),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_record_type    (o_record_type),
        .o_address        (o_address),
        .o_data_byte      (o_data_byte),
        .o_byte_offset    (o_byte_offset),
        .o_payload_length (o_payload_length),
        .o_checksum_ok    (o_checksum_ok),
        .o_error_code     (o_error_code)
    );

    always #1 i_clk = ~i_clk;

    // Line parser state mirrored by the predictor.
    logic [9:0]  char_pos = '0;
    logic [3:0]  rec_type = '0;
    logic [2:0]  addr_bytes = 3'd2;
    logic [31:0] rec_addr = '0;
    logic [7:0]  decl_count = '0;
    logic [7:0]  byte_sum = '0;
    logic [7:0]  hi_nib = '0;
    logic [7:0]  pay_index = '0;
    bit          skip_line = 1'b0;

    t_result     expected_beats [$];
    logic [7:0]  line_q [$];
    t_dir_row    directed_rows [24];

    int mismatches = 0;
    int live_chars = 0;
    int chars_sent = 0;
    int beats_data = 0;
    int beats_done = 0;
    int beats_done_ok = 0;
    int beats_reject = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    logic [7:0] stall_tick = '0;

    function automatic t_result make_beat(input logic [1:0] kind, input logic [3:0] rtype,
                                          input logic [31:0] addr, input logic [7:0] data,
                                          input logic [7:0] offs, input logic [7:0] plen,
                                          input logic ok, input logic [1:0] err);
        t_result r;
        r.kind = kind;
        r.record_type = rtype;
        r.address = addr;
        r.data_byte = data;
        r.byte_offset = offs;
        r.payload_length = plen;
        r.checksum_ok = ok;
        r.error_code = err;
        return r;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'("0" + n);
        return lower ? 8'("a" + n - 4'd10) : 8'("A" + n - 4'd10);
    endfunction

    // Any character but a line end.
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Payload size: count less address bytes less checksum, floored at zero.
    function automatic logic [7:0] payload_size();
        if (decl_count <= addr_bytes + 1) return 8'd0;
        return 8'(decl_count - addr_bytes - 1);
    endfunction

    task automatic clear_line();
        char_pos = '0;
        rec_type = '0;
        addr_bytes = 3'd2;
        rec_addr = '0;
        decl_count = '0;
        byte_sum = '0;
        hi_nib = '0;
        pay_index = '0;
        skip_line = 1'b0;
    endtask

    // Advance the line parser by one character and return the beat it causes.
    task automatic parse_char(input logic [7:0] c, output bit live, output bit got,
                              output t_result beat);
        logic [7:0] b;
        logic [2:0] nb;
        int idx;
        live = !skip_line;
        got = 1'b0;
        beat = NO_BEAT;
        if (c == CH_CR || c == CH_LF) begin
            if (!skip_line && char_pos != 0) begin
                got = 1'b1;
                if (char_pos == 1)
                    beat = make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                     ERR_BAD_TYPE);
                else
                    beat = make_beat(KIND_DONE, rec_type, rec_addr, 8'd0, 8'd0,
                                     payload_size(), byte_sum == 8'hFF, ERR_NONE);
            end
            clear_line();
        end else if (skip_line) begin
            got = 1'b0;
        end else if (char_pos == 0) begin
            if (c != CH_S) begin
                got = 1'b1;
                beat = make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0, ERR_NO_S);
                skip_line = 1'b1;
            end else begin
                char_pos = 10'd1;
            end
        end else if (char_pos == 1) begin
            case (c)
                "0", "1", "5", "9": nb = 3'd2;
                "2", "8":           nb = 3'd3;
                "3", "7":           nb = 3'd4;
                default:            nb = 3'd0;
            endcase
            if (nb == 0) begin
                got = 1'b1;
                beat = make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                 ERR_BAD_TYPE);
                skip_line = 1'b1;
            end else begin
                rec_type = 4'(c - "0");
                addr_bytes = nb;
                char_pos = 10'd2;
            end
        end else begin
            // Hex pairs: count, address, payload, checksum, then ignored bytes.
            if (!char_pos[0]) begin
                hi_nib = {4'd0, hex_value(c)};
            end else begin
                b = {hi_nib[3:0], hex_value(c)};
                idx = (char_pos - 10'd2) >> 1;
                if (idx == 0) begin
                    decl_count = b;
                    byte_sum = byte_sum + b;
                end else if (idx <= decl_count) begin
                    byte_sum = byte_sum + b;
                    if (idx <= addr_bytes) begin
                        rec_addr = {rec_addr[23:0], b};
                    end else if (pay_index < payload_size()) begin
                        got = 1'b1;
                        beat = make_beat(KIND_DATA, rec_type, rec_addr, b, pay_index,
                                         payload_size(), 1'b0, ERR_NONE);
                        pay_index = pay_index + 8'd1;
                    end
                end
            end
            if (char_pos < POS_LIMIT) char_pos = char_pos + 10'd1;
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Send one character in bursts with random gaps; predict once it is taken.
    task automatic send_char(input logic [7:0] c, input t_check_how how,
                             input t_result given, input bit counted);
        int gap;
        bit live;
        bit got;
        t_result beat;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 9) == 0 ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 24);
        end
        i_valid <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        chars_sent++;
        parse_char(c, live, got, beat);
        if (counted && live) live_chars++;
        if (how == CHK_GIVEN) expected_beats.push_back(given);
        else if (how == CHK_PRED && got) expected_beats.push_back(beat);
    endtask

    // Build one record line: well-formed mostly, with a few faults mixed in.
    task automatic build_record(input bit long_rec);
        logic [7:0] rec_bytes [$];
        logic [7:0] tc;
        logic [7:0] sum;
        logic [7:0] b;
        int nb;
        int cnt;
        int case_mode;
        int k;
        int cut;
        case ($urandom_range(0, 7))
            0:       tc = "0";
            1:       tc = "1";
            2:       tc = "2";
            3:       tc = "3";
            4:       tc = "5";
            5:       tc = "7";
            6:       tc = "8";
            default: tc = "9";
        endcase
        nb = (tc == "2" || tc == "8") ? 3 : (tc == "3" || tc == "7") ? 4 : 2;
        if (long_rec) cnt = 255;
        else if ($urandom_range(0, 19) == 0) cnt = $urandom_range(0, nb);
        else if ($urandom_range(0, 9) == 0) cnt = nb + 1 + $urandom_range(0, 40);
        else cnt = nb + 1 + $urandom_range(0, 8);
        case_mode = $urandom_range(0, 2);
        sum = 8'(cnt);
        rec_bytes.push_back(8'(cnt));
        for (k = 1; k <= cnt; k++) begin
            if (k == cnt && $urandom_range(0, 9) != 0) b = 8'hFF - sum;
            else if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else b = 8'($urandom_range(0, 255));
            sum = sum + b;
            rec_bytes.push_back(b);
        end
        // Bytes past the count are parsed but must not count.
        if (long_rec || $urandom_range(0, 14) == 0)
            repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom_range(0, 255)));
        line_q.push_back(CH_S);
        line_q.push_back(tc);
        foreach (rec_bytes[k]) begin
            line_q.push_back(hex_char(rec_bytes[k][7:4],
                                      case_mode == 2 ? bit'($urandom_range(0, 1))
                                                     : bit'(case_mode)));
            line_q.push_back(hex_char(rec_bytes[k][3:0],
                                      case_mode == 2 ? bit'($urandom_range(0, 1))
                                                     : bit'(case_mode)));
        end
        // Run the position counter into saturation.
        if (long_rec) repeat (540) line_q.push_back(text_byte());
        // A stray character anywhere, and a line cut short.
        if ($urandom_range(0, 14) == 0) line_q[$urandom_range(0, line_q.size() - 1)] = text_byte();
        if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(1, line_q.size() - 1);
            line_q = line_q[0:cut - 1];
        end
    endtask

    // The receiver stalls in randomly chosen modes that change over the run.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 8'd1;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= $urandom_range(0, 99) < 30;
            2:       i_stall <= $urandom_range(0, 99) < 80;
            default: i_stall <= stall_tick[2];
        endcase
    end

    // Compare every result beat with the oldest prediction.
    always @(posedge i_clk) begin : beat_check
        t_result seen;
        t_result want;
        string diffs;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = make_beat(o_kind, o_record_type, o_address, o_data_byte, o_byte_offset,
                             o_payload_length, o_checksum_ok, o_error_code);
            case (seen.kind)
                KIND_DATA: beats_data++;
                KIND_DONE: begin
                    beats_done++;
                    if (seen.checksum_ok) beats_done_ok++;
                end
                default:   beats_reject++;
            endcase
            if (expected_beats.size() == 0) begin
                note_failure($sformatf("unexpected beat %p", seen));
            end else begin
                want = expected_beats.pop_front();
                diffs = "";
                if (seen.kind !== want.kind) diffs = {diffs, " kind"};
                if (seen.record_type !== want.record_type) diffs = {diffs, " record_type"};
                if (seen.address !== want.address) diffs = {diffs, " address"};
                if (seen.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
                if (seen.byte_offset !== want.byte_offset) diffs = {diffs, " byte_offset"};
                if (seen.payload_length !== want.payload_length)
                    diffs = {diffs, " payload_length"};
                if (seen.checksum_ok !== want.checksum_ok) diffs = {diffs, " checksum_ok"};
                if (seen.error_code !== want.error_code) diffs = {diffs, " error_code"};
                if (diffs != "")
                    note_failure($sformatf("field(s)%s: expected %p, got %p",
                                           diffs, want, seen));
            end
        end
    end

    // Hard stop for a hung run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int waited;
        bit long_line;
        bit long_sent;
        long_sent = 1'b0;
        clear_line();

        // Directed lines: bad start, bad type, lone S, extreme characters,
        // an empty line and one short valid S1 record.
        directed_rows = '{
            '{"X",   CHK_GIVEN, make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                          ERR_NO_S)},
            '{CH_LF, CHK_NONE,  NO_BEAT},
            '{"S",   CHK_NONE,  NO_BEAT},
            '{"4",   CHK_GIVEN, make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                          ERR_BAD_TYPE)},
            '{CH_CR, CHK_NONE,  NO_BEAT},
            '{"S",   CHK_NONE,  NO_BEAT},
            '{CH_CR, CHK_GIVEN, make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                          ERR_BAD_TYPE)},
            '{CH_LF, CHK_NONE,  NO_BEAT},
            '{8'h00, CHK_GIVEN, make_beat(KIND_REJECT, 4'd0, 32'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                                          ERR_NO_S)},
            '{8'hFF, CHK_NONE,  NO_BEAT},
            '{CH_LF, CHK_NONE,  NO_BEAT},
            '{"S",   CHK_NONE,  NO_BEAT},
            '{"1",   CHK_NONE,  NO_BEAT},
            '{"0",   CHK_PRED,  NO_BEAT},
            '{"4",   CHK_PRED,  NO_BEAT},
            '{"1",   CHK_PRED,  NO_BEAT},
            '{"2",   CHK_PRED,  NO_BEAT},
            '{"3",   CHK_PRED,  NO_BEAT},
            '{"4",   CHK_PRED,  NO_BEAT},
            '{"A",   CHK_PRED,  NO_BEAT},
            '{"B",   CHK_GIVEN, make_beat(KIND_DATA, 4'd1, 32'h1234, 8'hAB, 8'd0, 8'd1, 1'b0,
                                          ERR_NONE)},
            '{"0",   CHK_PRED,  NO_BEAT},
            '{"A",   CHK_PRED,  NO_BEAT},
            '{CH_CR, CHK_GIVEN, make_beat(KIND_DONE, 4'd1, 32'h1234, 8'd0, 8'd0, 8'd1, 1'b1,
                                          ERR_NONE)}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_char(directed_rows[k].ch, directed_rows[k].how, directed_rows[k].given, 1'b0);

        // Random lines, one of them long enough to saturate the position count.
        while (live_chars < LIVE_CHAR_TARGET) begin
            line_q.delete();
            long_line = !long_sent && live_chars >= LIVE_CHAR_TARGET / 4;
            if (long_line) begin
                build_record(1'b1);
                long_sent = 1'b1;
            end else if ($urandom_range(0, 99) < 80) begin
                build_record(1'b0);
            end else begin
                // Noise: empty line, junk, S with any type byte, lone S.
                case ($urandom_range(0, 3))
                    0: ;
                    1: repeat ($urandom_range(1, 10)) line_q.push_back(text_byte());
                    2: begin
                        line_q.push_back(CH_S);
                        line_q.push_back(text_byte());
                        repeat ($urandom_range(0, 8)) line_q.push_back(text_byte());
                    end
                    default: line_q.push_back(CH_S);
                endcase
            end
            case ($urandom_range(0, 3))
                0:       line_q.push_back(CH_CR);
                1:       line_q.push_back(CH_LF);
                2:       begin line_q.push_back(CH_CR); line_q.push_back(CH_LF); end
                default: begin line_q.push_back(CH_LF); line_q.push_back(CH_CR); end
            endcase
            foreach (line_q[k]) send_char(line_q[k], CHK_PRED, NO_BEAT, 1'b1);
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle.
        waited = 0;
        while (expected_beats.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_beats.size() != 0)
            note_failure($sformatf("%0d predicted beats never arrived", expected_beats.size()));

        $display("Sent %0d characters; saw %0d payload beats, %0d records (%0d with good sum),",
                 chars_sent, beats_data, beats_done, beats_done_ok);
        $display("%0d rejected lines and %0d mismatches.", beats_reject, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/srec_pkg.sv
design/srec_in_reg.sv
design/srec_core.sv
design/srec_out_reg.sv
design/srecord_line_parser.sv
tb/srecord_line_parser_test.sv
